// ===== hw/rtl/line_follower_pid_drive_core_assert.svh =====
// Assertion macros for the line follower PID drive core.
`ifndef LINE_FOLLOWER_PID_DRIVE_CORE_ASSERT_SVH
`define LINE_FOLLOWER_PID_DRIVE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LFPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfpd: check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LFPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfpd: check failed");

`endif

// ===== hw/rtl/lfpd_pkg.sv =====
// Shared constants and types of the line follower PID drive core.
package lfpd_pkg;

    // Field widths
    localparam int SENSOR_W = 5;
    localparam int ERR_W    = 4;
    localparam int DERIV_W  = ERR_W + 1;
    localparam int SIDE_W   = 2;
    localparam int SPEED_W  = 8;
    localparam int GAIN_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int INTEG_W  = 24;
    localparam int ISUM_W   = INTEG_W + 1;

    // Product and sum widths of the PID datapath
    localparam int KP_PROD_W = GAIN_W + 1 + ERR_W;
    localparam int KI_PROD_W = GAIN_W + 1 + INTEG_W;
    localparam int KD_PROD_W = GAIN_W + 1 + DERIV_W;
    localparam int SUM_W     = GAIN_W + INTEG_W + 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KI   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KD   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BASE = 2'd3;

    // Register reset values
    localparam logic [GAIN_W-1:0]  KP_RST   = 24'd1179648;
    localparam logic [GAIN_W-1:0]  KI_RST   = 24'd7;
    localparam logic [GAIN_W-1:0]  KD_RST   = 24'd1310720;
    localparam logic [SPEED_W-1:0] BASE_RST = 8'd127;

    // Error limits
    localparam logic signed [ERR_W-1:0] ERR_MAX = 4'sd4;
    localparam logic signed [ERR_W-1:0] ERR_MIN = -4'sd4;

    // Side indicator codes
    localparam logic [SIDE_W-1:0] SIDE_NEG  = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_ZERO = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_POS  = 2'd2;

    // Classified item handed from front to back
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic [SIDE_W-1:0]         side;
        logic signed [INTEG_W-1:0] integ;
        logic signed [DERIV_W-1:0] deriv;
    } t_cls_item;

    // Configuration seen by the back end
    typedef struct packed {
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  ki;
        logic [GAIN_W-1:0]  kd;
        logic [SPEED_W-1:0] base;
    } t_gains;

endpackage

// ===== hw/rtl/lfpd_front.sv =====
// Front end: sensor decode, held error, saturating integral, derivative.
module lfpd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [lfpd_pkg::SENSOR_W-1:0] i_sensor_bits,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output lfpd_pkg::t_cls_item           o_item
);
    import lfpd_pkg::*;

    logic signed [ERR_W-1:0]   r_held_error;
    logic signed [ERR_W-1:0]   n_held_error;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [INTEG_W-1:0] n_integ;
    logic signed [ISUM_W-1:0]  w_sum;
    logic                      w_accept;

    // Pattern table; all dark follows the last side (zero counts as positive), unknown keeps the last error
    function automatic logic signed [ERR_W-1:0] decode_pattern(
        input logic [SENSOR_W-1:0]   bits,
        input logic signed [ERR_W-1:0] last
    );
        logic signed [ERR_W-1:0] e;
        case (bits)
            5'd16:   e = ERR_MAX;
            5'd24:   e = 4'sd3;
            5'd8:    e = 4'sd2;
            5'd12:   e = 4'sd1;
            5'd4:    e = 4'sd0;
            5'd6:    e = -4'sd1;
            5'd2:    e = -4'sd2;
            5'd3:    e = -4'sd3;
            5'd1:    e = ERR_MIN;
            5'd0:    e = (last < 0) ? ERR_MIN : ERR_MAX;
            default: e = last;
        endcase
        return e;
    endfunction

    assign w_accept = i_push & ~i_q_full;
    assign o_q_push = w_accept;

    // Classify the item and run the error and integral recurrence
    always_comb begin
        n_held_error = decode_pattern(i_sensor_bits, r_held_error);
        w_sum        = ISUM_W'(r_integ) + ISUM_W'(n_held_error);
        // saturate when the two top bits disagree
        if (w_sum[ISUM_W-1] != w_sum[ISUM_W-2]) begin
            n_integ = w_sum[ISUM_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                      : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            n_integ = w_sum[INTEG_W-1:0];
        end
        o_item.err   = n_held_error;
        o_item.integ = n_integ;
        o_item.deriv = DERIV_W'(n_held_error) - DERIV_W'(r_held_error);
        if (n_held_error < 0) begin
            o_item.side = SIDE_NEG;
        end else if (n_held_error == 0) begin
            o_item.side = SIDE_ZERO;
        end else begin
            o_item.side = SIDE_POS;
        end
    end

    // Loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_error <= '0;
            r_integ      <= '0;
        end else if (w_accept) begin
            r_held_error <= n_held_error;
            r_integ      <= n_integ;
        end
    end

endmodule

// ===== hw/rtl/lfpd_queue.sv =====
// Short item queue between front and back.
module lfpd_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  lfpd_pkg::t_cls_item         i_item,
    input  logic                        i_pop,
    output lfpd_pkg::t_cls_item         o_item,
    output logic                        o_full,
    output logic                        o_empty,
    output logic [lfpd_pkg::QCNT_W-1:0] o_count
);
    import lfpd_pkg::*;

    t_cls_item         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;
    assign o_item    = r_mem[r_rd_ptr];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/lfpd_back.sv =====
// Back end: three-stage PID multiply, sum and duty clamp with output register.
module lfpd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  lfpd_pkg::t_cls_item                 i_q_item,
    output logic                                o_q_pop,
    input  lfpd_pkg::t_gains                    i_gains,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic [lfpd_pkg::SPEED_W-1:0]        o_left_speed,
    output logic [lfpd_pkg::SPEED_W-1:0]        o_right_speed,
    output logic signed [lfpd_pkg::ERR_W-1:0]   o_line_error,
    output logic [lfpd_pkg::SIDE_W-1:0]         o_side_indicator
);
    import lfpd_pkg::*;

    // stage 1: products
    logic                        r_v1;
    logic signed [KP_PROD_W-1:0] r_p_kp;
    logic signed [KI_PROD_W-1:0] r_p_ki;
    logic signed [KD_PROD_W-1:0] r_p_kd;
    logic signed [ERR_W-1:0]     r_e1;
    logic [SIDE_W-1:0]           r_s1;
    // stage 2: PID sum
    logic                        r_v2;
    logic signed [SUM_W-1:0]     r_pid;
    logic signed [ERR_W-1:0]     r_e2;
    logic [SIDE_W-1:0]           r_s2;
    // stage 3: output register
    logic                        r_v3;
    logic [SPEED_W-1:0]          r_left;
    logic [SPEED_W-1:0]          r_right;
    logic signed [ERR_W-1:0]     r_e3;
    logic [SIDE_W-1:0]           r_s3;

    logic                        w_rdy1;
    logic                        w_rdy2;
    logic                        w_rdy3;
    logic signed [KP_PROD_W-1:0] w_p_kp;
    logic signed [KI_PROD_W-1:0] w_p_ki;
    logic signed [KD_PROD_W-1:0] w_p_kd;
    logic signed [SUM_W-1:0]     w_pid;
    logic signed [SUM_W-1:0]     w_base_q;
    logic signed [SUM_W-1:0]     w_left_q;
    logic signed [SUM_W-1:0]     w_right_q;

    // Whole part of a Q.16 value, clamped to the duty range
    function automatic logic [SPEED_W-1:0] duty_clamp(input logic signed [SUM_W-1:0] q);
        logic [SPEED_W-1:0] d;
        if (q[SUM_W-1]) begin
            d = '0;
        end else if (|q[SUM_W-2:FRAC_W+SPEED_W]) begin
            d = '1;
        end else begin
            d = q[FRAC_W+SPEED_W-1:FRAC_W];
        end
        return d;
    endfunction

    // Stall chain from the output backwards
    assign w_rdy3  = ~r_v3 | i_pop;
    assign w_rdy2  = ~r_v2 | w_rdy3;
    assign w_rdy1  = ~r_v1 | w_rdy2;
    assign o_q_pop = ~i_q_empty & w_rdy1;

    // Gains are unsigned, so they enter the signed products with a zero on top
    assign w_p_kp = KP_PROD_W'($signed({1'b0, i_gains.kp})) * KP_PROD_W'(i_q_item.err);
    assign w_p_ki = KI_PROD_W'($signed({1'b0, i_gains.ki})) * KI_PROD_W'(i_q_item.integ);
    assign w_p_kd = KD_PROD_W'($signed({1'b0, i_gains.kd})) * KD_PROD_W'(i_q_item.deriv);

    assign w_pid = SUM_W'(r_p_kp) + SUM_W'(r_p_ki) + SUM_W'(r_p_kd);

    // base * 2^16 plus and minus the PID value
    assign w_base_q  = $signed({{(SUM_W-SPEED_W-FRAC_W){1'b0}}, i_gains.base,
                                {FRAC_W{1'b0}}});
    assign w_left_q  = w_base_q + r_pid;
    assign w_right_q = w_base_q - r_pid;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= o_q_pop;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_p_kp <= w_p_kp;
            r_p_ki <= w_p_ki;
            r_p_kd <= w_p_kd;
            r_e1   <= i_q_item.err;
            r_s1   <= i_q_item.side;
        end
        if (w_rdy2 && r_v1) begin
            r_pid <= w_pid;
            r_e2  <= r_e1;
            r_s2  <= r_s1;
        end
        if (w_rdy3 && r_v2) begin
            r_left  <= duty_clamp(w_left_q);
            r_right <= duty_clamp(w_right_q);
            r_e3    <= r_e2;
            r_s3    <= r_s2;
        end
    end

    assign o_empty          = ~r_v3;
    assign o_left_speed     = r_left;
    assign o_right_speed    = r_right;
    assign o_line_error     = r_e3;
    assign o_side_indicator = r_s3;

endmodule

// ===== hw/rtl/line_follower_pid_drive_core.sv =====
// Top level of the line follower PID drive core: config registers and wiring.
//
// Input channel: drive i_sensor_bits and raise i_push; the item is taken at a
// clock edge where i_push is high and o_full is low. One sensor item per cycle
// is taken while o_full is low, as the front end updates its error and integral.
// Result channel: while o_empty is low the oldest result (left and right duty,
// line error, side indicator) is on the outputs; it is taken at an edge where
// i_pop is high. Exactly one result follows each item, in order.
// Each item passes the queue, the multiply stage, the sum stage and the clamp
// and output register. Sustained rate is one item per cycle while i_pop is high.
// If the receiver stalls, the back pipeline fills first and then the 4-entry
// queue; o_full rises only when both are full, and no item is lost.
// Reset (i_rst_n low at an edge) clears the held error, the integral, the
// queue and the valid bits, and loads the default gains and base speed.
// Configuration: i_cfg_we writes i_cfg_wdata into register i_cfg_addr
// (0 Kp, 1 Ki, 2 Kd as unsigned Q8.16; 3 base speed); write only when idle.
`include "line_follower_pid_drive_core_assert.svh"

module line_follower_pid_drive_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    output logic                                 o_full,
    input  logic [lfpd_pkg::SENSOR_W-1:0]        i_sensor_bits,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic [lfpd_pkg::SPEED_W-1:0]         o_left_speed,
    output logic [lfpd_pkg::SPEED_W-1:0]         o_right_speed,
    output logic signed [lfpd_pkg::ERR_W-1:0]    o_line_error,
    output logic [lfpd_pkg::SIDE_W-1:0]          o_side_indicator,
    input  logic                                 i_cfg_we,
    input  logic [lfpd_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [lfpd_pkg::GAIN_W-1:0]          i_cfg_wdata
);
    import lfpd_pkg::*;

    t_gains            r_gains;
    t_cls_item         w_cls;
    t_cls_item         w_q_item;
    logic              w_q_push;
    logic              w_q_pop;
    logic              w_q_full;
    logic              w_q_empty;
    logic [QCNT_W-1:0] w_q_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.kp   <= KP_RST;
            r_gains.ki   <= KI_RST;
            r_gains.kd   <= KD_RST;
            r_gains.base <= BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KP:   r_gains.kp   <= i_cfg_wdata;
                CFG_KI:   r_gains.ki   <= i_cfg_wdata;
                CFG_KD:   r_gains.kd   <= i_cfg_wdata;
                CFG_BASE: r_gains.base <= i_cfg_wdata[SPEED_W-1:0];
                default:  ;
            endcase
        end
    end

    assign o_full = w_q_full;

    // Front end: decode and loop state
    lfpd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_sensor_bits (i_sensor_bits),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_item        (w_cls)
    );

    // Decoupling queue
    lfpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_cls),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    // Back end: PID datapath and result register
    lfpd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (w_q_empty),
        .i_q_item         (w_q_item),
        .o_q_pop          (w_q_pop),
        .i_gains          (r_gains),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_left_speed     (o_left_speed),
        .o_right_speed    (o_right_speed),
        .o_line_error     (o_line_error),
        .o_side_indicator (o_side_indicator)
    );

    // Checks
    `LFPD_ASSERT_IMPL(a_err_range, w_q_push, (w_cls.err >= ERR_MIN) && (w_cls.err <= ERR_MAX))
    `LFPD_ASSERT_IMPL(a_side_sign, w_q_push, (w_cls.side == SIDE_NEG) == (w_cls.err < 0))
    `LFPD_ASSERT_IMPL(a_q_bound, 1'b1, w_q_count <= QCNT_W'(QUEUE_DEPTH))
    `LFPD_ASSERT_NEXT(a_q_fill, w_q_push && !w_q_pop, w_q_count == $past(w_q_count) + 1'b1)

endmodule
